// File: design/hcbd_pkg.sv
// Shared types and constants for the chunked body decoder.
// No dependencies; imported by every design module.
package hcbd_pkg;

  // Configuration register widths and reset values
  localparam int MaxChunkW = 31;
  localparam int LineLimW  = 16;
  localparam int LenW      = 32;
  localparam int CfgIdxW   = 2;

  localparam logic [MaxChunkW-1:0] MaxChunkRst = {MaxChunkW{1'b1}};
  localparam logic [LineLimW-1:0]  SizeLimRst  = LineLimW'(1024);
  localparam logic [LineLimW-1:0]  TrlLimRst   = LineLimW'(4096);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_CHUNK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_LIM  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRL_LIM   = 2'd2;

  typedef struct packed {
    logic [MaxChunkW-1:0] max_chunk;
    logic [LineLimW-1:0]  size_lim;
    logic [LineLimW-1:0]  trl_lim;
  } cfg_t;

  // One decoded result beat
  typedef struct packed {
    logic            body_valid;
    logic [7:0]      body_byte;
    logic            done_res;
    logic            error;
    logic [2:0]      error_code;
    logic [LenW-1:0] body_length;
  } step_res_t;

endpackage

// File: design/hcbd_cfg.sv
// Configuration register file of the chunked body decoder.
// Depends on hcbd_pkg for register indexes, widths and reset values.
module hcbd_cfg import hcbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [MaxChunkW-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_CHUNK: cfg_nxt.max_chunk = cfg_wdata;
        CFG_SIZE_LIM:  cfg_nxt.size_lim  = cfg_wdata[LineLimW-1:0];
        CFG_TRL_LIM:   cfg_nxt.trl_lim   = cfg_wdata[LineLimW-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_chunk <= MaxChunkRst;
      cfg_r.size_lim  <= SizeLimRst;
      cfg_r.trl_lim   <= TrlLimRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/hcbd_core.sv
// Parser state and per-byte transition logic of the chunked body decoder.
// Depends on hcbd_pkg for cfg_t and step_res_t.
module hcbd_core import hcbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       new_message,
  input  cfg_t       cfg,
  output step_res_t  res
);

  localparam logic [3:0] PH_LEAD       = 4'd0;
  localparam logic [3:0] PH_DIGITS     = 4'd1;
  localparam logic [3:0] PH_EXT        = 4'd2;
  localparam logic [3:0] PH_SIZE_LF    = 4'd3;
  localparam logic [3:0] PH_DATA       = 4'd4;
  localparam logic [3:0] PH_DATA_CR    = 4'd5;
  localparam logic [3:0] PH_DATA_LF    = 4'd6;
  localparam logic [3:0] PH_TRAILER    = 4'd7;
  localparam logic [3:0] PH_TRAILER_LF = 4'd8;
  localparam logic [3:0] PH_DONE       = 4'd9;
  localparam logic [3:0] PH_ERROR      = 4'd10;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_SIZE = 3'd1;
  localparam logic [2:0] ERR_SIZE_LEN = 3'd2;
  localparam logic [2:0] ERR_NO_CRLF  = 3'd3;
  localparam logic [2:0] ERR_TRL_LEN  = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c <= 8'h39)      d = c - 8'h30;
    else if (c >= 8'h61) d = c - 8'h57;
    else                 d = c - 8'h37;
    hex_val = d[3:0];
  endfunction

  logic [3:0]           phase_r,  phase_nxt;
  logic [MaxChunkW-1:0] chunk_r,  chunk_nxt;
  logic [MaxChunkW-1:0] recv_r,   recv_nxt;
  logic [LenW-1:0]      total_r,  total_nxt;
  logic [LineLimW-1:0]  lcount_r, lcount_nxt;
  logic [2:0]           err_r,    err_nxt;

  // Effective state after an optional new-message clear
  logic [3:0]           ph;
  logic [MaxChunkW-1:0] cs;
  logic [MaxChunkW-1:0] br;
  logic [LenW-1:0]      tl;
  logic [LineLimW-1:0]  lc;
  logic [2:0]           er;

  logic [MaxChunkW+3:0] dig_next;
  logic                 dig_bad;
  logic [LineLimW-1:0]  lc_inc;
  logic [LineLimW-1:0]  lc_inc2;
  logic [MaxChunkW-1:0] br_inc;
  logic                 sz_full, sz_full2, tr_full, tr_full2;
  logic                 beat_valid;

  always_comb begin
    ph = new_message ? PH_LEAD : phase_r;
    cs = new_message ? '0 : chunk_r;
    br = new_message ? '0 : recv_r;
    tl = new_message ? '0 : total_r;
    lc = new_message ? '0 : lcount_r;
    er = new_message ? ERR_NONE : err_r;

    dig_next = {cs, hex_val(data_byte)};
    dig_bad  = dig_next > {4'b0, cfg.max_chunk};
    lc_inc   = lc + LineLimW'(1);
    lc_inc2  = lc + LineLimW'(2);
    br_inc   = br + MaxChunkW'(1);
    sz_full  = lc >= cfg.size_lim;
    sz_full2 = lc_inc >= cfg.size_lim;
    tr_full  = lc >= cfg.trl_lim;
    tr_full2 = lc_inc >= cfg.trl_lim;

    phase_nxt  = ph;
    chunk_nxt  = cs;
    recv_nxt   = br;
    total_nxt  = tl;
    lcount_nxt = lc;
    err_nxt    = er;
    beat_valid = 1'b0;

    unique case (ph)
      // Leading blanks, then the first hex digit
      PH_LEAD: begin
        if (sz_full) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_SIZE_LEN;
        end else if (data_byte == CH_CR) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_BAD_SIZE;
        end else begin
          lcount_nxt = lc_inc;
          if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
            phase_nxt = PH_LEAD;
          end else if (!is_hex(data_byte) || dig_bad) begin
            phase_nxt = PH_ERROR; err_nxt = ERR_BAD_SIZE;
          end else begin
            phase_nxt = PH_DIGITS;
            chunk_nxt = dig_next[MaxChunkW-1:0];
          end
        end
      end
      // Size digits and extension up to CR
      PH_DIGITS, PH_EXT: begin
        if (data_byte == CH_CR) begin
          phase_nxt = PH_SIZE_LF;
        end else if (sz_full) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_SIZE_LEN;
        end else begin
          lcount_nxt = lc_inc;
          if (ph == PH_DIGITS) begin
            if (!is_hex(data_byte)) begin
              phase_nxt = PH_EXT;
            end else if (dig_bad) begin
              phase_nxt = PH_ERROR; err_nxt = ERR_BAD_SIZE;
            end else begin
              chunk_nxt = dig_next[MaxChunkW-1:0];
            end
          end
        end
      end
      // LF ends the size line; a lone CR counts as extension
      PH_SIZE_LF: begin
        if (data_byte == CH_LF) begin
          lcount_nxt = '0;
          recv_nxt   = '0;
          phase_nxt  = (cs == '0) ? PH_TRAILER : PH_DATA;
        end else if (sz_full) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_SIZE_LEN;
        end else if (data_byte == CH_CR) begin
          lcount_nxt = lc_inc;
          phase_nxt  = PH_SIZE_LF;
        end else if (sz_full2) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_SIZE_LEN;
        end else begin
          lcount_nxt = lc_inc2;
          phase_nxt  = PH_EXT;
        end
      end
      // Forward payload, saturate the running length
      PH_DATA: begin
        beat_valid = 1'b1;
        if (tl != {LenW{1'b1}}) total_nxt = tl + LenW'(1);
        recv_nxt = br_inc;
        if (br_inc >= cs) phase_nxt = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (data_byte == CH_CR) begin
          phase_nxt = PH_DATA_LF;
        end else begin
          phase_nxt = PH_ERROR; err_nxt = ERR_NO_CRLF;
        end
      end
      PH_DATA_LF: begin
        if (data_byte == CH_LF) begin
          phase_nxt  = PH_LEAD;
          chunk_nxt  = '0;
          lcount_nxt = '0;
        end else begin
          phase_nxt = PH_ERROR; err_nxt = ERR_NO_CRLF;
        end
      end
      // Skip trailer lines, count their length
      PH_TRAILER: begin
        if (data_byte == CH_CR) begin
          phase_nxt = PH_TRAILER_LF;
        end else if (tr_full) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_TRL_LEN;
        end else begin
          lcount_nxt = lc_inc;
        end
      end
      PH_TRAILER_LF: begin
        if (data_byte == CH_LF) begin
          if (lc == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            lcount_nxt = '0;
            phase_nxt  = PH_TRAILER;
          end
        end else if (tr_full) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_TRL_LEN;
        end else if (data_byte == CH_CR) begin
          lcount_nxt = lc_inc;
          phase_nxt  = PH_TRAILER_LF;
        end else if (tr_full2) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_TRL_LEN;
        end else begin
          lcount_nxt = lc_inc2;
          phase_nxt  = PH_TRAILER;
        end
      end
      // Done and error hold until a new message
      default: begin
        phase_nxt = ph;
      end
    endcase
  end

  // Advance state once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      chunk_r  <= '0;
      recv_r   <= '0;
      total_r  <= '0;
      lcount_r <= '0;
      err_r    <= ERR_NONE;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      chunk_r  <= chunk_nxt;
      recv_r   <= recv_nxt;
      total_r  <= total_nxt;
      lcount_r <= lcount_nxt;
      err_r    <= err_nxt;
    end
  end

  always_comb begin
    res.body_valid  = beat_valid;
    res.body_byte   = beat_valid ? data_byte : 8'h00;
    res.done_res    = phase_nxt == PH_DONE;
    res.error       = phase_nxt == PH_ERROR;
    res.error_code  = err_nxt;
    res.body_length = total_nxt;
  end

endmodule

// File: design/http_chunked_body_decoder.sv
// Chunked transfer body decoder: one result beat for every input byte.
// An accepted byte passes the input reg, parser logic and result reg; out_stall can hold it.
// Throughput: 1 byte per cycle unless out_stall holds the result register.
// Reset (rst_n low, synchronous): parser waits for a size line, pipeline empty,
// registers return to max chunk 2^31-1, size line limit 1024, trailer limit 4096.
module http_chunked_body_decoder import hcbd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_new_message,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_body_valid,
  output logic [7:0]           out_body_byte,
  output logic                 out_done_res,
  output logic                 out_error,
  output logic [2:0]           out_error_code,
  output logic [LenW-1:0]      out_body_length,
  input  logic                 cfg_wr_en,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [MaxChunkW-1:0] cfg_wdata
);

  cfg_t      cfg;
  step_res_t res;
  step_res_t res_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_new_r;
  logic       out_valid_r, out_valid_nxt;
  logic       step_en;
  logic       in_take;

  hcbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hcbd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .data_byte   (s1_byte_r),
    .new_message (s1_new_r),
    .cfg         (cfg),
    .res         (res)
  );

  // Process the held byte when the result register is free or draining
  assign step_en  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !step_en;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !step_en);
    out_valid_nxt = step_en || (out_valid_r && out_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_new_r  <= in_new_message;
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_body_valid  = res_r.body_valid;
  assign out_body_byte   = res_r.body_byte;
  assign out_done_res    = res_r.done_res;
  assign out_error       = res_r.error;
  assign out_error_code  = res_r.error_code;
  assign out_body_length = res_r.body_length;

endmodule

// File: design/hcbd_checker.sv
// Port-level checker for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg for field widths.
module hcbd_checker import hcbd_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input logic            out_body_valid,
  input logic [7:0]      out_body_byte,
  input logic            out_done_res,
  input logic            out_error,
  input logic [2:0]      out_error_code,
  input logic [LenW-1:0] out_body_length
);

  // A finished body and an error never show together
  a_done_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_res && out_error))
    else $error("done and error both set");

  // Error flag agrees with the reason code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error == (out_error_code != 3'd0)))
    else $error("error flag and error code disagree");

  // A payload beat never arrives once the body is finished or failed
  a_no_payload_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_body_valid |-> !out_done_res && !out_error)
    else $error("payload byte after done or error");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_body_length)
      && $stable(out_body_byte) && $stable(out_error_code))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_body_valid  (out_body_valid),
  .out_body_byte   (out_body_byte),
  .out_done_res    (out_done_res),
  .out_error       (out_error),
  .out_error_code  (out_error_code),
  .out_body_length (out_body_length)
);
